// ----- rtl/xterm_key_sequence_encoder_unit_macros.svh -----
// Assertion macros shared by the key sequence encoder modules.
// Expects signals clk and arst_n in the scope of every use.
`ifndef XTERM_KEY_SEQUENCE_ENCODER_UNIT_MACROS_SVH
`define XTERM_KEY_SEQUENCE_ENCODER_UNIT_MACROS_SVH

// property holds at every clock edge outside reset
`define KSE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define KSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/kse_pkg.sv -----
// Package for the xterm key sequence encoder: codes, byte constants, queue types.
// No dependencies; used by kse_front, kse_queue, kse_back and the top level.
`default_nettype none

package kse_pkg;

	// text handling
	localparam int MAX_TEXT_BYTES = 4;
	localparam int TEXT_CAP       = (MAX_TEXT_BYTES < 4) ? MAX_TEXT_BYTES : 4;

	// sequence buffer: longest is ESC [ 2 4 ; 8 ~
	localparam int SEQ_MAX = 7;
	localparam int LEN_W   = $clog2(SEQ_MAX + 1);
	localparam int IDX_W   = $clog2(SEQ_MAX);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// key codes
	localparam logic [4:0] KEY_CHAR   = 5'd0;
	localparam logic [4:0] KEY_ENTER  = 5'd1;
	localparam logic [4:0] KEY_TAB    = 5'd2;
	localparam logic [4:0] KEY_BKSP   = 5'd3;
	localparam logic [4:0] KEY_ESCAPE = 5'd4;
	localparam logic [4:0] KEY_UP     = 5'd5;
	localparam logic [4:0] KEY_LEFT   = 5'd8;
	localparam logic [4:0] KEY_HOME   = 5'd9;
	localparam logic [4:0] KEY_END    = 5'd10;
	localparam logic [4:0] KEY_PGUP   = 5'd11;
	localparam logic [4:0] KEY_PGDN   = 5'd12;
	localparam logic [4:0] KEY_DELETE = 5'd13;
	localparam logic [4:0] KEY_INSERT = 5'd14;
	localparam logic [4:0] KEY_F1     = 5'd15;
	localparam logic [4:0] KEY_F4     = 5'd18;
	localparam logic [4:0] KEY_F5     = 5'd19;
	localparam logic [4:0] KEY_F12    = 5'd26;

	// key actions
	localparam logic [1:0] ACT_PRESS  = 2'd0;
	localparam logic [1:0] ACT_REPEAT = 2'd1;

	// modifier bits
	localparam int MOD_SHIFT = 0;
	localparam int MOD_ALT   = 1;
	localparam int MOD_CTRL  = 2;
	localparam logic [3:0] MODS_SHIFT_ONLY = 4'b0001;

	// bytes
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_CSI   = 8'h5b; // '['
	localparam logic [7:0] CH_SS3   = 8'h4f; // 'O'
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_Z     = 8'h5a;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_US    = 8'h5f; // '_'
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CTRL_MASK = 8'h1f;

	// one queued sequence
	typedef struct packed {
		logic [SEQ_MAX-1:0][7:0] bytes;
		logic [LEN_W-1:0]        len;
	} seq_t;

	// number in the CSI n~ form for the tilde keys
	function automatic logic [4:0] tilde_code(input logic [4:0] key);
		logic [4:0] v;
		v = 5'd0;
		unique case (key)
			KEY_PGUP:   v = 5'd5;
			KEY_PGDN:   v = 5'd6;
			KEY_DELETE: v = 5'd3;
			KEY_INSERT: v = 5'd2;
			5'd19:      v = 5'd15;
			5'd20:      v = 5'd17;
			5'd21:      v = 5'd18;
			5'd22:      v = 5'd19;
			5'd23:      v = 5'd20;
			5'd24:      v = 5'd21;
			5'd25:      v = 5'd23;
			5'd26:      v = 5'd24;
			default:    v = 5'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/kse_if.sv -----
// Channel interfaces: key events in, sequence bytes out, valid/ready handshake.
// Does not depend on kse_pkg; widths are the fixed field widths.
`default_nettype none

interface kse_key_if;
	logic        valid;
	logic        ready;
	logic [4:0]  key_code;
	logic [3:0]  modifier_bits;
	logic [1:0]  key_action;
	logic [2:0]  text_length;
	logic [31:0] text_bytes;

	modport source (output valid, key_code, modifier_bits, key_action, text_length,
		text_bytes, input ready);
	modport sink (input valid, key_code, modifier_bits, key_action, text_length,
		text_bytes, output ready);
endinterface

interface kse_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/kse_front.sv -----
// Front end: registers a key event, classifies it and builds its byte sequence.
// Depends on kse_pkg and kse_key_if; pushes complete sequences to kse_queue.
`default_nettype none

module kse_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	kse_key_if.sink          key_event,
	input  wire logic        app_mode,
	input  wire logic        q_full,
	output kse_pkg::seq_t    push_seq,
	output logic             push
);
	import kse_pkg::*;

	logic        valid_s1;
	logic [4:0]  key_s1;
	logic [3:0]  mods_s1;
	logic [1:0]  action_s1;
	logic [2:0]  tlen_s1;
	logic [31:0] text_s1;

	logic        emit;
	logic        advance;
	seq_t        seq;

	// request moves on when queued, or drops when it makes no bytes
	assign advance         = valid_s1 && (!emit || !q_full);
	assign push            = valid_s1 && emit && !q_full;
	assign push_seq        = seq;
	assign key_event.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_event.ready) begin
			valid_s1 <= key_event.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_event.ready && key_event.valid) begin
			key_s1    <= key_event.key_code;
			mods_s1   <= key_event.modifier_bits;
			action_s1 <= key_event.key_action;
			tlen_s1   <= key_event.text_length;
			text_s1   <= key_event.text_bytes;
		end
	end

	// classify and build the sequence
	always_comb begin
		logic [3:0]      mod_p;
		logic [2:0]      tlen_c;
		logic [3:0][7:0] body;
		logic [2:0]      blen;
		logic            use_meta;
		logic            letter;
		logic            tilde;
		logic            ss3;
		logic [7:0]      fin;
		logic [4:0]      tcode;
		logic [4:0]      ones;
		logic [2:0]      pos;

		mod_p    = 4'({1'b0, mods_s1[MOD_CTRL], mods_s1[MOD_ALT], mods_s1[MOD_SHIFT]} + 4'd1);
		tlen_c   = (tlen_s1 > 3'(TEXT_CAP)) ? 3'(TEXT_CAP) : tlen_s1;
		body     = '0;
		blen     = '0;
		use_meta = 1'b0;
		letter   = 1'b0;
		tilde    = 1'b0;
		ss3      = 1'b0;
		fin      = '0;
		tcode    = '0;
		ones     = '0;
		pos      = '0;
		seq      = '0;
		emit     = 1'b0;

		if (action_s1 == ACT_PRESS || action_s1 == ACT_REPEAT) begin
			priority if (key_s1 == KEY_CHAR) begin
				for (int i = 0; i < TEXT_CAP; i++) begin
					body[i] = text_s1[8*i +: 8];
				end
				// ctrl folds a single character in @ to _, a to z or space to a control byte
				if (mods_s1[MOD_CTRL] && tlen_c == 3'd1) begin
					if ((body[0] >= CH_AT && body[0] <= CH_US) ||
						(body[0] >= CH_LA && body[0] <= CH_LZ) || body[0] == CH_SPACE) begin
						body[0] = body[0] & CTRL_MASK;
					end
				end
				blen     = tlen_c;
				use_meta = (tlen_c != 3'd0);
			end else if (key_s1 == KEY_ENTER) begin
				body[0]  = CH_CR;
				blen     = 3'd1;
				use_meta = 1'b1;
			end else if (key_s1 == KEY_TAB) begin
				if (mods_s1 == MODS_SHIFT_ONLY) begin
					seq.bytes[0] = CH_ESC;
					seq.bytes[1] = CH_CSI;
					seq.bytes[2] = CH_Z;
					seq.len      = LEN_W'(3);
					emit         = 1'b1;
				end else begin
					body[0]  = CH_TAB;
					blen     = 3'd1;
					use_meta = 1'b1;
				end
			end else if (key_s1 == KEY_BKSP) begin
				body[0]  = CH_DEL;
				blen     = 3'd1;
				use_meta = 1'b1;
			end else if (key_s1 == KEY_ESCAPE) begin
				body[0]  = CH_ESC;
				blen     = 3'd1;
				use_meta = 1'b1;
			end else if (key_s1 >= KEY_UP && key_s1 <= KEY_LEFT) begin
				letter = 1'b1;
				ss3    = app_mode;
				fin    = 8'(CH_A + {3'd0, key_s1 - KEY_UP});
			end else if (key_s1 == KEY_HOME) begin
				letter = 1'b1;
				fin    = CH_H;
			end else if (key_s1 == KEY_END) begin
				letter = 1'b1;
				fin    = CH_F;
			end else if (key_s1 >= KEY_PGUP && key_s1 <= KEY_INSERT) begin
				tilde = 1'b1;
			end else if (key_s1 >= KEY_F1 && key_s1 <= KEY_F4) begin
				letter = 1'b1;
				ss3    = 1'b1;
				fin    = 8'(CH_P + {3'd0, key_s1 - KEY_F1});
			end else if (key_s1 >= KEY_F5 && key_s1 <= KEY_F12) begin
				tilde = 1'b1;
			end else begin
				emit = 1'b0;
			end
		end

		// text-like keys, with ESC in front under alt
		if (use_meta) begin
			if (mods_s1[MOD_ALT]) begin
				seq.bytes[0] = CH_ESC;
				pos          = 3'd1;
			end
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < blen) begin
					seq.bytes[pos + 3'(i)] = body[i];
				end
			end
			seq.len = LEN_W'(pos + blen);
			emit    = 1'b1;
		end

		// ESC O x, ESC [ x or ESC [ 1 ; p x
		if (letter) begin
			seq.bytes[0] = CH_ESC;
			if (mod_p == 4'd1) begin
				seq.bytes[1] = ss3 ? CH_SS3 : CH_CSI;
				seq.bytes[2] = fin;
				seq.len      = LEN_W'(3);
			end else begin
				seq.bytes[1] = CH_CSI;
				seq.bytes[2] = CH_ONE;
				seq.bytes[3] = CH_SEMI;
				seq.bytes[4] = 8'(CH_ZERO + {4'd0, mod_p});
				seq.bytes[5] = fin;
				seq.len      = LEN_W'(6);
			end
			emit = 1'b1;
		end

		// ESC [ n ~ or ESC [ n ; p ~
		if (tilde) begin
			tcode        = tilde_code(key_s1);
			seq.bytes[0] = CH_ESC;
			seq.bytes[1] = CH_CSI;
			pos          = 3'd2;
			if (tcode >= 5'd20) begin
				seq.bytes[pos] = 8'(CH_ZERO + 8'd2);
				pos            = pos + 3'd1;
				ones           = tcode - 5'd20;
			end else if (tcode >= 5'd10) begin
				seq.bytes[pos] = CH_ONE;
				pos            = pos + 3'd1;
				ones           = tcode - 5'd10;
			end else begin
				ones = tcode;
			end
			seq.bytes[pos] = 8'(CH_ZERO + {3'd0, ones});
			pos            = pos + 3'd1;
			if (mod_p != 4'd1) begin
				seq.bytes[pos]         = CH_SEMI;
				seq.bytes[pos + 3'd1]  = 8'(CH_ZERO + {4'd0, mod_p});
				pos                    = pos + 3'd2;
			end
			seq.bytes[pos] = CH_TILDE;
			seq.len        = LEN_W'(pos + 3'd1);
			emit           = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/kse_queue.sv -----
// Short queue of built sequences between the front end and the serializer.
// Depends on kse_pkg for seq_t and the depth; macros from the project header.
`default_nettype none

module kse_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire kse_pkg::seq_t push_seq,
	input  wire logic          pop,
	output logic               full,
	output logic               head_valid,
	output kse_pkg::seq_t      head
);
	import kse_pkg::*;

`include "xterm_key_sequence_encoder_unit_macros.svh"

	seq_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_seq;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`KSE_ASSERT(a_no_overflow, !(push && full), "push into a full queue")
	`KSE_ASSERT(a_no_underflow, !(pop && !head_valid), "pop from an empty queue")
	`KSE_ASSERT(a_count_range, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
	`KSE_ASSERT(a_ptr_match, (count_q == '0 || full) |-> (wr_ptr_q == rd_ptr_q), "queue pointers disagree with fill level")

endmodule

`default_nettype wire

// ----- rtl/kse_back.sv -----
// Back end: walks the head sequence of the queue and sends it one byte per request.
// Depends on kse_pkg and kse_byte_if; macros from the project header.
`default_nettype none

module kse_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire kse_pkg::seq_t head,
	output logic               pop,
	kse_byte_if.source         seq_byte
);
	import kse_pkg::*;

`include "xterm_key_sequence_encoder_unit_macros.svh"

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic [IDX_W-1:0] idx_q;

	logic load;
	logic take;
	logic is_last;

	// output register refills when empty or taken
	assign load    = !out_valid_q || seq_byte.ready;
	assign take    = load && head_valid;
	assign is_last = (LEN_W'(idx_q) + LEN_W'(1)) == head.len;
	assign pop     = take && is_last;

	assign seq_byte.valid     = out_valid_q;
	assign seq_byte.out_byte  = out_byte_q;
	assign seq_byte.last_byte = last_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (take) begin
				idx_q <= is_last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= head.bytes[idx_q];
			last_q     <= is_last;
		end
	end

	`KSE_ASSERT(a_idx_in_seq, head_valid |-> (LEN_W'(idx_q) < head.len), "byte index past end of sequence")
	`KSE_ASSERT(a_idx_idle, !head_valid |-> (idx_q == '0), "byte index moved with no sequence")
	`KSE_ASSERT(a_no_empty_seq, head_valid |-> (head.len != '0), "empty sequence queued")
	`KSE_ASSERT_NEXT(a_last_on_pop, pop, out_valid_q && last_q, "sequence popped without marking its last byte")

endmodule

`default_nettype wire

// ----- rtl/xterm_key_sequence_encoder_unit.sv -----
// Top level of the xterm key sequence encoder: config register, front end, queue, back end.
// Depends on kse_pkg, kse_if, kse_front, kse_queue and kse_back.
`default_nettype none

// Takes one key event per request and sends the bytes a legacy xterm-style terminal
// sends for it, one byte per output request, with last_byte set on the final byte.
// Releases, key codes above KEY_F12 and empty text send nothing. The front end
// registers an event and builds its whole sequence combinationally, then hands it
// to a two-entry queue; a new event can be taken every cycle while the queue has
// room. The back end sends one byte per cycle from the queue head while the output
// is ready; a sequence has 1 to 7 bytes, ESC [ 2 4 ; 8 ~ being the longest, and
// that serializer sets the sustained rate. An event passes the input register, a
// queue entry and the output register on its way out. cfg_wdata written under cfg_we
// sets cursor application mode (reset 0); write it only while the block is idle.
module xterm_key_sequence_encoder_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	kse_key_if.sink   key_event,
	kse_byte_if.source seq_byte,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);
	import kse_pkg::*;

	logic app_mode_q;
	logic q_full;
	logic push;
	logic pop;
	logic head_valid;
	seq_t push_seq;
	seq_t head;

	// cursor application mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_mode_q <= 1'b0;
		end else if (cfg_we) begin
			app_mode_q <= cfg_wdata;
		end
	end

	kse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_event (key_event),
		.app_mode  (app_mode_q),
		.q_full    (q_full),
		.push_seq  (push_seq),
		.push      (push)
	);

	kse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_seq   (push_seq),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	kse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.seq_byte   (seq_byte)
	);

endmodule

`default_nettype wire
